### hw/rtl/dnsqb_pkg.sv
// shared types, constants and helper functions of the dns query builder
package dnsqb_pkg;

	localparam int MAX_PACKET_DEF = 512;
	localparam int MAX_LABEL_DEF  = 63;

	localparam int CAP_W   = 10;
	localparam int POS_W   = CAP_W + 1;
	localparam int CNT_W   = 7;
	localparam int STEP_W  = 4;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [POS_W-1:0]  HDR_LEN    = POS_W'(12);
	localparam logic [STEP_W-1:0] HDR_LAST   = STEP_W'(11);
	localparam logic [STEP_W-1:0] TAIL_LAST  = STEP_W'(5);
	localparam logic [POS_W-1:0]  TAIL_LEN   = POS_W'(5);
	localparam logic [15:0]       DNS_FLAGS  = 16'h0100;
	localparam logic [15:0]       QD_COUNT   = 16'h0001;
	localparam logic [15:0]       QCLASS_IN  = 16'h0001;
	localparam logic [7:0]        CHAR_DOT   = 8'd46;
	localparam logic [7:0]        CHAR_END   = 8'd0;

	localparam logic [CAP_W-1:0] CAPACITY_RST   = CAP_W'(512);
	localparam logic [15:0]      QUERY_TYPE_RST = 16'd15;

	localparam logic [2:0] ADDR_CAPACITY   = 3'd0;
	localparam logic [2:0] ADDR_QUERY_TYPE = 3'd4;

	typedef enum logic [1:0] {
		CMD_HDR,
		CMD_ONE,
		CMD_ERR,
		CMD_TAIL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [15:0]      txn_id;
		logic [POS_W-1:0] pos_a;
		logic [7:0]       byte_a;
		logic [POS_W-1:0] base;
	} cmd_t;

	function automatic logic [7:0] hdr_byte(input logic [15:0] id, input logic [STEP_W-1:0] idx);
		logic [7:0] b;
		b = 8'd0;
		case (idx)
			4'd0: b = id[15:8];
			4'd1: b = id[7:0];
			4'd2: b = DNS_FLAGS[15:8];
			4'd3: b = DNS_FLAGS[7:0];
			4'd4: b = QD_COUNT[15:8];
			4'd5: b = QD_COUNT[7:0];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	// idx 0 is the root terminator, then qtype and qclass big-endian
	function automatic logic [7:0] tail_byte(input logic [15:0] qtype, input logic [STEP_W-1:0] idx);
		logic [7:0] b;
		b = 8'd0;
		case (idx)
			4'd1: b = qtype[15:8];
			4'd2: b = qtype[7:0];
			4'd3: b = QCLASS_IN[15:8];
			4'd4: b = QCLASS_IN[7:0];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

### hw/rtl/dnsqb_front.sv
// front end: accepts items, tracks label state and issues write commands
module dnsqb_front #(
	parameter int MAX_LABEL = dnsqb_pkg::MAX_LABEL_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [15:0]                 txn_id,
	input  logic [7:0]                  char_code,
	input  logic [dnsqb_pkg::POS_W-1:0] eff_cap,
	input  logic                        q_full,
	output logic                        q_push,
	output dnsqb_pkg::cmd_t             q_cmd
);
	import dnsqb_pkg::*;

	logic             active_q, active_d;
	logic [POS_W-1:0] write_pos_q, write_pos_d;
	logic [POS_W-1:0] label_pos_q, label_pos_d;
	logic [CNT_W-1:0] label_cnt_q, label_cnt_d;
	logic             acc;
	logic             bad_label;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	assign bad_label = (label_cnt_q == '0) || (label_cnt_q > CNT_W'(MAX_LABEL));

	always_comb begin
		active_d    = active_q;
		write_pos_d = write_pos_q;
		label_pos_d = label_pos_q;
		label_cnt_d = label_cnt_q;
		q_push      = 1'b0;
		q_cmd       = '0;
		q_cmd.kind  = CMD_ONE;
		if (acc) begin
			if (!req_type) begin
				q_push        = 1'b1;
				q_cmd.kind    = CMD_HDR;
				q_cmd.txn_id  = txn_id;
				active_d      = (eff_cap >= HDR_LEN);
				label_pos_d   = HDR_LEN;
				write_pos_d   = HDR_LEN + POS_W'(1);
				label_cnt_d   = '0;
			end else if (active_q) begin
				q_push = 1'b1;
				if (char_code == CHAR_DOT || char_code == CHAR_END) begin
					if (bad_label) begin
						q_cmd.kind = CMD_ERR;
						active_d   = 1'b0;
					end else if (char_code == CHAR_END) begin
						q_cmd.kind   = CMD_TAIL;
						q_cmd.pos_a  = label_pos_q;
						q_cmd.byte_a = {1'b0, label_cnt_q};
						q_cmd.base   = write_pos_q;
						active_d     = 1'b0;
					end else begin
						q_cmd.kind   = CMD_ONE;
						q_cmd.pos_a  = label_pos_q;
						q_cmd.byte_a = {1'b0, label_cnt_q};
						if (label_pos_q >= eff_cap) begin
							active_d = 1'b0;
						end else begin
							label_pos_d = write_pos_q;
							write_pos_d = write_pos_q + POS_W'(1);
							label_cnt_d = '0;
						end
					end
				end else begin
					q_cmd.kind   = CMD_ONE;
					q_cmd.pos_a  = write_pos_q;
					q_cmd.byte_a = char_code;
					if (write_pos_q >= eff_cap) begin
						active_d = 1'b0;
					end else begin
						write_pos_d = write_pos_q + POS_W'(1);
						// saturates one past the limit, enough to flag the label
						if (label_cnt_q <= CNT_W'(MAX_LABEL)) begin
							label_cnt_d = label_cnt_q + CNT_W'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			write_pos_q <= '0;
			label_pos_q <= '0;
			label_cnt_q <= '0;
		end else begin
			active_q    <= active_d;
			write_pos_q <= write_pos_d;
			label_pos_q <= label_pos_d;
			label_cnt_q <= label_cnt_d;
		end
	end

endmodule

### hw/rtl/dnsqb_cmd_fifo.sv
// short command queue between front and back
module dnsqb_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dnsqb_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output dnsqb_pkg::cmd_t head_cmd
);
	import dnsqb_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

### hw/rtl/dnsqb_back.sv
// back end: expands commands to byte writes, one item per unstalled cycle
module dnsqb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  dnsqb_pkg::cmd_t             head_cmd,
	output logic                        pop,
	input  logic [dnsqb_pkg::POS_W-1:0] eff_cap,
	input  logic [15:0]                 query_type,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [8:0]                  offset,
	output logic [7:0]                  out_byte,
	output logic                        is_error,
	output logic                        done_res,
	output logic [9:0]                  query_length,
	output logic                        last
);
	import dnsqb_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [8:0]        offset_q;
	logic [7:0]        byte_q;
	logic              err_q;
	logic              done_q;
	logic [9:0]        len_q;
	logic              last_q;

	logic [POS_W-1:0]  pos;
	logic [7:0]        wbyte;
	logic              force_err;
	logic              final_step;
	logic              err;
	logic              done;
	logic [POS_W-1:0]  total_len;
	logic              advance;
	logic              res_last;
	logic [STEP_W-1:0] tail_idx;

	assign tail_idx  = step_q - STEP_W'(1);
	assign total_len = head_cmd.base + TAIL_LEN;

	always_comb begin
		pos        = head_cmd.pos_a;
		wbyte      = head_cmd.byte_a;
		force_err  = 1'b0;
		final_step = 1'b1;
		unique case (head_cmd.kind)
			CMD_HDR: begin
				pos        = POS_W'(step_q);
				wbyte      = hdr_byte(head_cmd.txn_id, step_q);
				final_step = (step_q == HDR_LAST);
			end
			CMD_ONE: begin
				final_step = 1'b1;
			end
			CMD_ERR: begin
				force_err = 1'b1;
			end
			CMD_TAIL: begin
				// step zero closes the last label, then five tail bytes
				if (step_q != '0) begin
					pos   = head_cmd.base + POS_W'(tail_idx);
					wbyte = tail_byte(query_type, tail_idx);
				end
				final_step = (step_q == TAIL_LAST);
			end
			default: begin
				force_err = 1'b1;
			end
		endcase
	end

	assign err      = force_err || (pos >= eff_cap);
	assign done     = !err && final_step && (head_cmd.kind == CMD_TAIL);
	assign res_last = err || final_step;
	assign advance  = head_valid && (!out_valid_q || out_ready);
	assign pop      = advance && res_last;

	always_ff @(posedge clk) begin
		if (advance) begin
			offset_q <= err ? 9'd0 : pos[8:0];
			byte_q   <= err ? 8'd0 : wbyte;
			err_q    <= err;
			done_q   <= done;
			len_q    <= done ? total_len[9:0] : 10'd0;
			last_q   <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				step_q <= res_last ? '0 : step_q + STEP_W'(1);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign offset       = offset_q;
	assign out_byte     = byte_q;
	assign is_error     = err_q;
	assign done_res     = done_q;
	assign query_length = len_q;
	assign last         = last_q;

endmodule

### hw/rtl/dns_query_builder_top.sv
// top level of the dns query builder: config registers, front, queue and back
//  - s_axis carries one item per handshake: tuser selects start (0) or name
//    character (1); tdata holds the transaction id and the character
//  - a start item yields the 12 header bytes as 12 result items; a name
//    character yields one item; the closing zero yields up to six items
//    (label length, terminator, qtype, qclass); any error yields one error
//    item and ends the query
//  - m_axis carries one result item per cycle while tready is high, tlast on the
//    final item of each input item; characters while no query is open give nothing
//  - path: with the queue empty, an accepted item is written into a queue
//    slot, and its first result is then registered in the output register
//  - throughput: one input item per cycle when each gives one result and m_axis
//    does not stall; the back end emits one result item per cycle and a
//    four-entry command queue absorbs header and tail bursts, so s_axis_tready
//    only drops while the queue is full
//  - when m_axis stalls the output register holds, the back end stops and
//    the queue fills before the input side is held off
//  - reset clears the query state and the queue; capacity returns to 512
//    and query_type to 15 (mx); no clearing pass is needed
//  - apb writes capacity (0x0), query_type (0x4); user must write only while idle, not enforced
module dns_query_builder_top #(
	parameter int MAX_LABEL  = dnsqb_pkg::MAX_LABEL_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // txn_id[15:0], char_code[23:16]
	input  logic        s_axis_tuser,   // req_type
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // offset[8:0], out_byte[16:9], query_length[26:17], zero pad
	output logic [1:0]  m_axis_tuser,   // is_error[0], done_res[1]
	output logic        m_axis_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dnsqb_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic [15:0]      query_type_q;
	logic [POS_W-1:0] eff_cap;
	logic             cfg_wr;

	logic             q_push;
	cmd_t             q_cmd;
	logic             q_full;
	logic             q_pop;
	logic             head_valid;
	cmd_t             head_cmd;

	logic [8:0]       res_offset;
	logic [7:0]       res_byte;
	logic             res_err;
	logic             res_done;
	logic [9:0]       res_len;

	// apb: zero wait state, write on the access cycle
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CAPACITY_RST;
			query_type_q <= QUERY_TYPE_RST;
		end else if (cfg_wr) begin
			if (paddr == ADDR_CAPACITY) begin
				capacity_q <= pwdata[CAP_W-1:0];
			end else if (paddr == ADDR_QUERY_TYPE) begin
				query_type_q <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == ADDR_CAPACITY) begin
			prdata = 32'(capacity_q);
		end else if (paddr == ADDR_QUERY_TYPE) begin
			prdata = 32'(query_type_q);
		end
	end

	// capacity beyond the packet buffer acts as the buffer size
	assign eff_cap = (32'(capacity_q) > MAX_PACKET_DEF) ? POS_W'(MAX_PACKET_DEF)
		: POS_W'(capacity_q);

	// front: label bookkeeping at one item per cycle while the queue is not full
	dnsqb_front #(
		.MAX_LABEL (MAX_LABEL)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.req_type  (s_axis_tuser),
		.txn_id    (s_axis_tdata[15:0]),
		.char_code (s_axis_tdata[23:16]),
		.eff_cap   (eff_cap),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	// queue of pending write commands
	dnsqb_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// back: one byte write per cycle into the output register while m_axis is not stalled
	dnsqb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (q_pop),
		.eff_cap      (eff_cap),
		.query_type   (query_type_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.offset       (res_offset),
		.out_byte     (res_byte),
		.is_error     (res_err),
		.done_res     (res_done),
		.query_length (res_len),
		.last         (m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, res_len, res_byte, res_offset};
	assign m_axis_tuser = {res_done, res_err};

endmodule

### dv/tb.sv
// self-checking testbench of the dns query builder: directed table, then random queries
module tb;
	import dnsqb_pkg::*;

	// req_type codes of an input item
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_CHAR  = 1'b1;

	// cycles without any handshake before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	// long receiver hold-off used to back the block up into its input
	localparam int HOLD_CYCLES = 150;

	// one packet write as it leaves the block
	typedef struct packed {
		logic [8:0] offset;
		logic [7:0] data;
		logic       err;
		logic       done;
		logic [9:0] qlen;
		logic       last;
	} pkt_write_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_op_t;

	// one row of the directed table: an item, or a register write between items
	typedef struct {
		row_op_t     op;
		logic [2:0]  addr;
		logic        req;
		logic [15:0] id;
		logic [7:0]  ch;
		bit          typed;
		pkt_write_t  last_write;
	} stim_row_t;

	logic        clk;
	logic        arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;   // txn_id[15:0], char_code[23:16]
	logic        s_axis_tuser  = 1'b0; // req_type

	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // offset[8:0], out_byte[16:9], query_length[26:17]
	logic [1:0]  m_axis_tuser;         // is_error[0], done_res[1]
	logic        m_axis_tlast;

	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	dns_query_builder_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// packet encoder: our own copy of the builder state and registers
	// ---------------------------------------------------------------
	int unsigned cap_reg   = 512;
	logic [15:0] qtype_reg = 16'd15;
	int unsigned wr_pos;
	int unsigned lbl_pos;
	int unsigned lbl_len;
	bit          query_open;

	// writes still owed by the block, oldest first
	pkt_write_t  pkt_writes[$];
	// writes of the item being encoded
	pkt_write_t  item_writes[$];

	int          fails;
	int          productive_items;
	bit          tx_fast;
	bit          rx_fast;
	bit          hold_req;
	int          idle_cycles;
	stim_row_t   stim_rows[$];

	// abort: a single error write, query closed
	function automatic void push_abort();
		pkt_write_t w;
		w = '0;
		w.err = 1'b1;
		item_writes.push_back(w);
		query_open = 1'b0;
	endfunction

	// a write at or past the usable size turns into an abort
	function automatic bit push_write(int unsigned pos, logic [7:0] b);
		pkt_write_t  w;
		int unsigned usable;
		usable = (cap_reg > MAX_PACKET_DEF) ? MAX_PACKET_DEF : cap_reg;
		if (pos >= usable) begin
			push_abort();
			return 1'b0;
		end
		w = '0;
		w.offset = pos[8:0];
		w.data = b;
		item_writes.push_back(w);
		return 1'b1;
	endfunction

	// back-patch the label length, empty or oversized labels abort
	function automatic bit close_label();
		if (lbl_len == 0 || lbl_len > MAX_LABEL_DEF) begin
			push_abort();
			return 1'b0;
		end
		return push_write(lbl_pos, lbl_len[7:0]);
	endfunction

	function automatic int encode_item(logic req, logic [15:0] id, logic [7:0] ch);
		logic [7:0] hdr[12];
		logic [7:0] tl[5];
		bit         ok;
		item_writes.delete();
		if (req == REQ_START) begin
			// a start always wins, even over an open query
			foreach (hdr[i])
				hdr[i] = 8'h00;
			hdr[0] = id[15:8];
			hdr[1] = id[7:0];
			hdr[2] = DNS_FLAGS[15:8];
			hdr[3] = DNS_FLAGS[7:0];
			hdr[4] = QD_COUNT[15:8];
			hdr[5] = QD_COUNT[7:0];
			query_open = 1'b1;
			lbl_pos = 12;
			wr_pos = 13;
			lbl_len = 0;
			for (int i = 0; i < 12; i++) begin
				if (!push_write(i, hdr[i]))
					break;
			end
		end else if (query_open) begin
			if (ch == CHAR_DOT) begin
				if (close_label()) begin
					lbl_pos = wr_pos;
					wr_pos = wr_pos + 1;
					lbl_len = 0;
				end
			end else if (ch == CHAR_END) begin
				if (close_label()) begin
					tl[0] = 8'h00;
					tl[1] = qtype_reg[15:8];
					tl[2] = qtype_reg[7:0];
					tl[3] = QCLASS_IN[15:8];
					tl[4] = QCLASS_IN[7:0];
					ok = 1'b1;
					for (int i = 0; i < 5; i++) begin
						if (!push_write(wr_pos, tl[i])) begin
							ok = 1'b0;
							break;
						end
						wr_pos = wr_pos + 1;
					end
					if (ok) begin
						item_writes[item_writes.size()-1].done = 1'b1;
						item_writes[item_writes.size()-1].qlen = wr_pos[9:0];
						query_open = 1'b0;
					end
				end
			end else if (push_write(wr_pos, ch)) begin
				wr_pos = wr_pos + 1;
				// saturates one past the limit, enough to flag on close
				if (lbl_len <= MAX_LABEL_DEF)
					lbl_len = lbl_len + 1;
			end
		end
		if (item_writes.size() > 0)
			item_writes[item_writes.size()-1].last = 1'b1;
		foreach (item_writes[i])
			pkt_writes.push_back(item_writes[i]);
		return item_writes.size();
	endfunction

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------

	// offer one item after a random gap, encode it on acceptance;
	// tvalid stays high into the next call when that one has no gap
	task automatic send_item(logic req, logic [15:0] id, logic [7:0] ch);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ch, id};
		s_axis_tuser  <= req;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (encode_item(req, id, ch) > 0)
			productive_items++;
	endtask

	// stop offering and wait until every owed write has come out
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pkt_writes.size() != 0)
			@(posedge clk);
		// ignored items may still sit in the block
		repeat (4) @(posedge clk);
	endtask

	// end any open query with dots: a second dot is an empty label
	task automatic close_query();
		while (query_open)
			send_item(REQ_CHAR, 16'h0000, CHAR_DOT);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_CAPACITY)
			cap_reg = 32'(data[CAP_W-1:0]);
		else if (addr == ADDR_QUERY_TYPE)
			qtype_reg = data[15:0];
	endtask

	// registers only change with the block quiet and no query open
	task automatic set_reg(logic [2:0] addr, logic [31:0] data);
		close_query();
		drain_results();
		apb_write(addr, data);
	endtask

	// one well-formed query with random content; forced_len > 0 fixes
	// the first label, and now and then a label is empty, long, or the
	// query is left without its closing zero
	task automatic run_query(int forced_len);
		int         nlab;
		int         len;
		int         pick;
		logic [7:0] c;
		send_item(REQ_START, 16'($urandom), 8'($urandom));
		nlab = $urandom_range(1, 3);
		for (int l = 0; l < nlab; l++) begin
			if (l > 0)
				send_item(REQ_CHAR, 16'($urandom), CHAR_DOT);
			pick = $urandom_range(0, 29);
			if (l == 0 && forced_len > 0)
				len = forced_len;
			else if (pick == 0)
				len = 0;
			else if (pick == 1)
				len = $urandom_range(62, 65);
			else
				len = $urandom_range(1, 8);
			for (int k = 0; k < len; k++) begin
				c = 8'($urandom_range(1, 255));
				if (c == CHAR_DOT)
					c = 8'd45;
				send_item(REQ_CHAR, 16'($urandom), c);
			end
		end
		if ($urandom_range(0, 9) != 0)
			send_item(REQ_CHAR, 16'($urandom), CHAR_END);
	endtask

	function automatic void add_item(logic req, logic [15:0] id, logic [7:0] ch, bit typed,
			int off, int b, bit err, bit done, int len);
		stim_row_t r;
		r.op = ROW_ITEM;
		r.addr = '0;
		r.req = req;
		r.id = id;
		r.ch = ch;
		r.typed = typed;
		r.last_write = {off[8:0], b[7:0], err, done, len[9:0], 1'b1};
		stim_rows.push_back(r);
	endfunction

	function automatic void add_cfg(logic [2:0] addr, logic [15:0] val);
		stim_row_t r;
		r.op = ROW_CFG;
		r.addr = addr;
		r.req = REQ_CHAR;
		r.id = val;
		r.ch = '0;
		r.typed = 1'b0;
		r.last_write = '0;
		stim_rows.push_back(r);
	endfunction

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		int unsigned cap_set[5];
		logic [15:0] qtype_set[5];
		cap_set   = '{1023, 40, 512, 16, 300};
		qtype_set = '{16'h00FF, 16'hAAAA, 16'h5555, 16'h8001, 16'h000F};
		fails = 0;
		tx_fast = 1'b0;
		rx_fast = 1'b0;
		hold_req = 1'b0;
		query_open = 1'b0;
		wr_pos = 0;
		lbl_pos = 0;
		lbl_len = 0;

		// directed table: typed rows give the last write of that item
		add_item(REQ_CHAR,  16'h0000, 8'd65,  0,  0,   0, 0, 0,  0); // char while idle
		add_item(REQ_START, 16'hFFFF, 8'hFF,  1, 11,   0, 0, 0,  0); // header, all-ones id
		add_item(REQ_CHAR,  16'h0000, 8'd97,  1, 13,  97, 0, 0,  0);
		add_item(REQ_CHAR,  16'h0000, CHAR_DOT, 1, 12,  1, 0, 0,  0); // length patched back
		add_item(REQ_CHAR,  16'h0000, CHAR_DOT, 1,  0,  0, 1, 0,  0); // empty label
		add_item(REQ_CHAR,  16'hFFFF, 8'd120, 0,  0,   0, 0, 0,  0); // ignored after abort
		add_item(REQ_START, 16'h0000, 8'h00,  1, 11,   0, 0, 0,  0); // all-zero id
		add_item(REQ_CHAR,  16'h0000, 8'hFF,  1, 13, 255, 0, 0,  0);
		add_item(REQ_CHAR,  16'h0000, 8'h01,  1, 14,   1, 0, 0,  0);
		add_item(REQ_CHAR,  16'h0000, CHAR_END, 1, 19,  1, 0, 1, 20); // complete query
		add_item(REQ_START, 16'h1234, 8'h00,  0,  0,   0, 0, 0,  0);
		add_item(REQ_CHAR,  16'h0000, 8'd113, 0,  0,   0, 0, 0,  0);
		add_item(REQ_START, 16'hA55A, 8'h00,  1, 11,   0, 0, 0,  0); // start while open
		add_item(REQ_CHAR,  16'h0000, CHAR_END, 1,  0,  0, 1, 0,  0); // zero on empty label
		add_cfg(ADDR_CAPACITY, 16'd16);
		add_item(REQ_START, 16'h0102, 8'h00,  1, 11,   0, 0, 0,  0);
		add_item(REQ_CHAR,  16'h0000, 8'd97,  0,  0,   0, 0, 0,  0);
		add_item(REQ_CHAR,  16'h0000, 8'd98,  0,  0,   0, 0, 0,  0);
		add_item(REQ_CHAR,  16'h0000, CHAR_END, 1,  0,  0, 1, 0,  0); // tail overflows
		add_cfg(ADDR_CAPACITY, 16'd5);
		add_item(REQ_START, 16'h4242, 8'h00,  1,  0,   0, 1, 0,  0); // header overflows
		add_item(REQ_CHAR,  16'h0000, 8'd97,  0,  0,   0, 0, 0,  0);
		add_cfg(ADDR_CAPACITY, 16'd1023);                            // clamps to max packet
		add_cfg(ADDR_QUERY_TYPE, 16'hFFFF);
		add_item(REQ_START, 16'h00FF, 8'h00,  1, 11,   0, 0, 0,  0);
		add_item(REQ_CHAR,  16'h0000, CHAR_DOT, 1,  0,  0, 1, 0,  0); // dot right after header
		add_item(REQ_START, 16'h8000, 8'h00,  1, 11,   0, 0, 0,  0);
		add_item(REQ_CHAR,  16'h0000, 8'd122, 0,  0,   0, 0, 0,  0);
		add_item(REQ_CHAR,  16'h0000, CHAR_END, 1, 18,  1, 0, 1, 19);
		add_cfg(ADDR_QUERY_TYPE, 16'h0000);

		// reset once, before the directed table runs
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].op == ROW_CFG) begin
				set_reg(stim_rows[i].addr, {16'h0000, stim_rows[i].id});
			end else begin
				send_item(stim_rows[i].req, stim_rows[i].id, stim_rows[i].ch);
				// the item was just accepted, so its writes sit at the back
				if (stim_rows[i].typed) begin
					if (item_writes.size() == 0)
						pkt_writes.push_back(stim_rows[i].last_write);
					else
						pkt_writes[pkt_writes.size()-1] = stim_rows[i].last_write;
				end
			end
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < 5; ph++) begin
			set_reg(ADDR_CAPACITY, cap_set[ph]);
			set_reg(ADDR_QUERY_TYPE, {16'h0000, qtype_set[ph]});
			// phase 2 backs the block up: no sender gaps, long receiver hold
			tx_fast = (ph == 2) || (ph == 4);
			rx_fast = (ph == 4);
			if (ph == 2)
				hold_req = 1'b1;
			productive_items = 0;
			if (ph == 0) begin
				// a label right at the length limit
				run_query(63);
			end
			while (productive_items < 4) begin
				if (ph == 1 || ph == 3)
					tx_fast = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 7) == 0)
					send_item(1'($urandom), 16'($urandom), 8'($urandom));
				else
					run_query(0);
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// receiver: random stall before each result, one long hold on request
	// ---------------------------------------------------------------
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = rx_fast ? 0 : $urandom_range(0, 19);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	// ---------------------------------------------------------------
	// checker: each accepted write against the oldest one owed
	// ---------------------------------------------------------------
	function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	pkt_write_t owed;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pkt_writes.size() == 0) begin
				$error("unexpected result item: tdata %h tuser %b tlast %b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				fails++;
			end else begin
				owed = pkt_writes.pop_front();
				cmp_field("offset", 32'(owed.offset), 32'(m_axis_tdata[8:0]));
				cmp_field("out_byte", 32'(owed.data), 32'(m_axis_tdata[16:9]));
				cmp_field("is_error", 32'(owed.err), 32'(m_axis_tuser[0]));
				cmp_field("done_res", 32'(owed.done), 32'(m_axis_tuser[1]));
				cmp_field("query_length", 32'(owed.qlen), 32'(m_axis_tdata[26:17]));
				cmp_field("last", 32'(owed.last), 32'(m_axis_tlast));
			end
		end
	end

	// watchdog: too long without any handshake means the block hung
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= HANG_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
